// ===== rtl/bsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear sampler package
// Shared types and constants for the bilinear sampler with gradients.
// ----------------------------------------------------------------------------
`default_nettype none
package bsg_pkg;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam int unsigned CSR_ROW_WIDTH = 0;
   localparam int unsigned CSR_ROW_COUNT = 1;

   localparam int unsigned CSR_WIDTH = 9;
   localparam int unsigned POS_WIDTH = 16;

   typedef struct packed {
      logic        func;
      logic [15:0] pixel_addr;
      logic [7:0]  pixel_value;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
   } req_type;

   typedef struct packed {
      logic [23:0] intensity;
      logic [24:0] grad_x;
      logic [24:0] grad_y;
      logic        value_ok;
      logic        gradient_ok;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/bsg_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries write and sample items.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsg_req_if;
   logic             valid;
   logic             ready;
   bsg_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries sample results.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsg_rsp_if;
   logic             valid;
   logic             ready;
   bsg_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bilinear_sample_with_gradient.sv =====
// ----------------------------------------------------------------------------
// Bilinear sampler with gradient
// Samples an 8-bit image bilinearly and returns central-difference gradients.
// ----------------------------------------------------------------------------
// The block takes one item per cycle, write or sample, while the output is not
// stalled. A sample result passes the decode, read, blend, difference, rescale
// and output registers; write items give no result. The image is kept in
// sixteen full copies, one per cell of the 4x4 window, so the twelve pixels of
// a neighborhood come out of a single read at any row width. Every write goes
// to all copies, and the rate is set by the single read port of each copy. A
// stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Out-of-image neighborhoods raise no ok flag and give zero for those fields.
`default_nettype none
module bilinear_sample_with_gradient #(
   parameter int unsigned MAX_DIM   = 256,
   parameter int unsigned FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bsg_req_if.sink          req,
   bsg_rsp_if.source        rsp,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [8:0]  csr_data
);
   localparam int unsigned AW    = $clog2(MAX_DIM * MAX_DIM);
   localparam int unsigned WW    = FRAC_BITS + 1;
   localparam int unsigned SW    = 8 + 2 * WW;           // one bilinear sum
   localparam int unsigned STAGES = 7;

   // ---------------- configuration ----------------
   logic [8:0] row_width_ff, row_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= 9'd256;
         row_count_ff <= 9'd256;
      end else if (csr_write) begin
         if (csr_index == 1'(bsg_pkg::CSR_ROW_WIDTH)) row_width_ff <= csr_data;
         else row_count_ff <= csr_data;
      end
   end

   // ---------------- pipeline control ----------------
   logic advance;
   logic [STAGES-1:0] v_ff, v_in;
   assign advance   = !v_ff[STAGES-1] || rsp.ready;
   assign req.ready = advance;

   // ---------------- stage 1: decode ----------------
   logic             acc;
   bsg_pkg::req_type r;
   assign acc = req.valid && req.ready;
   assign r   = req.data;

   logic [bsg_pkg::POS_WIDTH-1:0] ix, iy;
   logic                          vok, gok;
   assign ix  = r.x_pos >> FRAC_BITS;
   assign iy  = r.y_pos >> FRAC_BITS;
   assign vok = (32'(ix) + 32'd1 < 32'(row_width_ff))
                && (32'(iy) + 32'd1 < 32'(row_count_ff));
   assign gok = (ix != '0) && (iy != '0) && (32'(ix) + 32'd2 < 32'(row_width_ff))
                && (32'(iy) + 32'd2 < 32'(row_count_ff));

   logic                 s1_write_ff, s1_vok_ff, s1_gok_ff;
   logic [AW-1:0]        s1_base_ff;        // (iy-1)*width + ix-1
   logic [AW-1:0]        s1_waddr_ff;
   logic [7:0]           s1_wdata_ff;
   logic [FRAC_BITS-1:0] s1_fx_ff, s1_fy_ff;
   logic [8:0]           s1_width_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_write_ff <= acc && (r.func == bsg_pkg::FUNC_WRITE);
         s1_vok_ff   <= vok;
         s1_gok_ff   <= gok;
         s1_base_ff  <= AW'((32'(iy) - 32'd1) * 32'(row_width_ff) + 32'(ix) - 32'd1);
         s1_waddr_ff <= AW'(r.pixel_addr);
         s1_wdata_ff <= r.pixel_value;
         s1_fx_ff    <= r.x_pos[FRAC_BITS-1:0];
         s1_fy_ff    <= r.y_pos[FRAC_BITS-1:0];
         s1_width_ff <= row_width_ff;
      end
   end

   // ---------------- stage 2: read addresses ----------------
   // Each of the 16 cells of the 4x4 window needs its own address; the
   // store is a flat array, so the banks are replicas indexed by cell.
   logic [AW-1:0] cell_addr [16];
   always_comb begin
      for (int c = 0; c < 16; c++) begin
         cell_addr[c] = AW'(32'(s1_base_ff) + (c / 4) * 32'(s1_width_ff) + (c % 4));
      end
   end

   logic [7:0] pix [16];
   for (genvar c = 0; c < 16; c++) begin : g_bank
      bsg_ram #(.WIDTH(8), .DEPTH(MAX_DIM * MAX_DIM)) u_ram (
         .clock   (clock),
         .wr_en   (s1_write_ff && advance),
         .wr_addr (s1_waddr_ff),
         .wr_data (s1_wdata_ff),
         .rd_en   (advance),
         .rd_addr (cell_addr[c]),
         .rd_data (pix[c])
      );
   end

   logic s2_vok_ff, s2_gok_ff;
   logic [FRAC_BITS-1:0] s2_fx_ff, s2_fy_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_vok_ff <= s1_vok_ff;
         s2_gok_ff <= s1_gok_ff;
         s2_fx_ff  <= s1_fx_ff;
         s2_fy_ff  <= s1_fy_ff;
      end
   end

   // ---------------- stage 3: horizontal blends ----------------
   // p(col,row) = pix[row*4+col], window origin at (ix-1, iy-1).
   logic [WW-1:0] wx0, wx1, wy0, wy1;
   assign wx1 = WW'(s2_fx_ff);
   assign wx0 = WW'(1 << FRAC_BITS) - wx1;
   assign wy1 = WW'(s2_fy_ff);
   assign wy0 = WW'(1 << FRAC_BITS) - wy1;

   // h_ff[r][k]: horizontal blend of columns k,k+1 in row r (k = 0..2).
   logic [8+WW-1:0] h_ff [4][3];
   // vc_ff[c][k]: vertical blend of rows k,k+1 in column c.
   logic [8+WW-1:0] vc_ff [4][3];
   logic [WW-1:0]   s3_wx0_ff, s3_wx1_ff, s3_wy0_ff, s3_wy1_ff;
   logic s3_vok_ff, s3_gok_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int rr = 0; rr < 4; rr++) begin
            for (int k = 0; k < 3; k++) begin
               h_ff[rr][k]  <= (8+WW)'(wx0 * pix[rr*4+k] + wx1 * pix[rr*4+k+1]);
               vc_ff[rr][k] <= (8+WW)'(wy0 * pix[k*4+rr] + wy1 * pix[(k+1)*4+rr]);
            end
         end
         s3_wx0_ff <= wx0; s3_wx1_ff <= wx1;
         s3_wy0_ff <= wy0; s3_wy1_ff <= wy1;
         s3_vok_ff <= s2_vok_ff; s3_gok_ff <= s2_gok_ff;
      end
   end

   // ---------------- stage 4: second blends ----------------
   // Center: rows 1,2 of horizontal blend k=1. Left: k=0, right: k=2.
   // Top: column blends k=0 over columns 1,2; bottom: k=2.
   logic [SW-1:0] cen_ff, lft_ff, rgt_ff, top_ff, bot_ff;
   logic s4_vok_ff, s4_gok_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cen_ff <= SW'(s3_wy0_ff * h_ff[1][1] + s3_wy1_ff * h_ff[2][1]);
         lft_ff <= SW'(s3_wy0_ff * h_ff[1][0] + s3_wy1_ff * h_ff[2][0]);
         rgt_ff <= SW'(s3_wy0_ff * h_ff[1][2] + s3_wy1_ff * h_ff[2][2]);
         top_ff <= SW'(s3_wx0_ff * vc_ff[1][0] + s3_wx1_ff * vc_ff[2][0]);
         bot_ff <= SW'(s3_wx0_ff * vc_ff[1][2] + s3_wx1_ff * vc_ff[2][2]);
         s4_vok_ff <= s3_vok_ff; s4_gok_ff <= s3_gok_ff;
      end
   end

   // ---------------- stage 5: differences ----------------
   logic signed [SW:0] dx_ff, dy_ff;
   logic [SW-1:0]      s5_cen_ff;
   logic s5_vok_ff, s5_gok_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= $signed({1'b0, rgt_ff}) - $signed({1'b0, lft_ff});
         dy_ff <= $signed({1'b0, bot_ff}) - $signed({1'b0, top_ff});
         s5_cen_ff <= cen_ff;
         s5_vok_ff <= s4_vok_ff; s5_gok_ff <= s4_gok_ff;
      end
   end

   // ---------------- stage 6: rescale ----------------
   // Gradient difference carries 2*FRAC_BITS fraction bits and is not halved;
   // shifting to 16 fraction bits floors, which arithmetic shift does.
   localparam int FB = 2 * FRAC_BITS;
   logic signed [SW+16:0] dxw, dyw;
   logic        [SW+15:0] cw;
   assign dxw = (SW+17)'(dx_ff);
   assign dyw = (SW+17)'(dy_ff);
   assign cw  = (SW+16)'(s5_cen_ff);

   logic [23:0] s6_int_ff;
   logic [24:0] s6_gx_ff, s6_gy_ff;
   logic s6_vok_ff, s6_gok_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s6_int_ff <= !s5_vok_ff ? '0 :
            (FB >= 16 ? 24'(cw >> (FB - 16)) : 24'(cw << (16 - FB)));
         s6_gx_ff <= !s5_gok_ff ? '0 :
            (FB >= 16 ? 25'(dxw >>> (FB - 16)) : 25'(dxw <<< (16 - FB)));
         s6_gy_ff <= !s5_gok_ff ? '0 :
            (FB >= 16 ? 25'(dyw >>> (FB - 16)) : 25'(dyw <<< (16 - FB)));
         s6_vok_ff <= s5_vok_ff; s6_gok_ff <= s5_gok_ff;
      end
   end

   // ---------------- stage 7: output register ----------------
   bsg_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.intensity   <= s6_int_ff;
         out_ff.grad_x      <= s6_gx_ff;
         out_ff.grad_y      <= s6_gy_ff;
         out_ff.value_ok    <= s6_vok_ff;
         out_ff.gradient_ok <= s6_gok_ff;
      end
   end

   always_comb begin
      v_in    = {v_ff[STAGES-2:0], acc && (r.func == bsg_pkg::FUNC_SAMPLE)};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   assign rsp.valid = v_ff[STAGES-1];
   assign rsp.data  = out_ff;

   // ---------------- assertions ----------------
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready does not follow output stall");
   a_zero_int: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.value_ok |-> rsp.data.intensity == '0)
      else $error("intensity not zero outside image");
   a_zero_grad: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.gradient_ok |-> rsp.data.grad_x == '0 && rsp.data.grad_y == '0)
      else $error("gradient not zero outside image");
   a_gok_vok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.gradient_ok |-> rsp.data.value_ok)
      else $error("gradient ok without value ok");
endmodule
`default_nettype wire

// ===== rtl/bsg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bsg_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire
